// ===== design/hsfc_pkg.sv =====
// Package with shared constants and the request word type for the half/single converter.
`timescale 1ns / 1ps

package hsfc_pkg;

   localparam logic FUNC_NARROW = 1'b0;
   localparam logic FUNC_WIDEN  = 1'b1;

   localparam logic [15:0] HALF_INF  = 16'h7C00;
   localparam logic [15:0] HALF_QNAN = 16'h7E00;
   localparam logic [7:0]  SINGLE_EXP_MAX = 8'hFF;
   localparam logic [7:0]  SINGLE_BIAS = 8'd127;
   localparam logic [7:0]  HALF_BIAS = 8'd15;

   typedef struct packed {
      logic        func;
      logic [31:0] value;
   } req_word_type;

endpackage

// ===== design/hsfc_convert.sv =====
// Combinational conversion of one word in either direction.
`timescale 1ns / 1ps

module hsfc_convert (
   input  logic                 func,
   input  logic [31:0]          value,
   output logic [31:0]          result
);

   logic        s_sign;
   logic [7:0]  s_exp;
   logic [22:0] s_man;
   logic [23:0] s_full;
   logic [23:0] s_shifted;
   logic [3:0]  s_sh;
   logic [15:0] narrow_w;

   logic        h_sign;
   logic [4:0]  h_exp;
   logic [9:0]  h_man;
   logic [3:0]  h_top;
   logic [9:0]  h_norm;
   logic [31:0] widen_w;

   always_comb begin
      s_sign = value[31];
      s_exp = value[30:23];
      s_man = value[22:0];
      s_full = {1'b1, s_man};
      // Denormal shift is 1..10 for biased exponents 103..112.
      s_sh = 4'(8'd113 - s_exp);
      s_shifted = s_full >> s_sh;
      if (s_exp == hsfc_pkg::SINGLE_EXP_MAX) begin
         narrow_w = {s_sign, (s_man == 23'd0) ? hsfc_pkg::HALF_INF[14:0]
                                             : hsfc_pkg::HALF_QNAN[14:0]};
      end else if (s_exp < 8'd103) begin
         narrow_w = {s_sign, 15'd0};
      end else if (s_exp < 8'd113) begin
         narrow_w = {s_sign, 5'd0, s_shifted[22:13]};
      end else if (s_exp > 8'd142) begin
         narrow_w = {s_sign, hsfc_pkg::HALF_INF[14:0]};
      end else begin
         narrow_w = {s_sign, 5'(s_exp - hsfc_pkg::SINGLE_BIAS + hsfc_pkg::HALF_BIAS),
                     s_man[22:13]};
      end
   end

   always_comb begin
      h_sign = value[15];
      h_exp = value[14:10];
      h_man = value[9:0];
      h_top = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_man[i]) h_top = 4'(i);
      end
      h_norm = h_man << (4'd10 - h_top);
      if (h_exp == 5'd0) begin
         if (h_man == 10'd0) widen_w = {h_sign, 31'd0};
         else widen_w = {h_sign, 8'(h_top) + 8'd103, h_norm, 13'd0};
      end else if (h_exp == 5'd31) begin
         widen_w = {h_sign, hsfc_pkg::SINGLE_EXP_MAX, h_man, 13'd0};
      end else begin
         widen_w = {h_sign, 8'(h_exp) + 8'd112, h_man, 13'd0};
      end
   end

   assign result = (func == hsfc_pkg::FUNC_WIDEN) ? widen_w : {16'd0, narrow_w};

endmodule

// ===== design/half_single_float_converter_core.sv =====
// Top level of the half/single float bit-pattern converter.
`timescale 1ns / 1ps
// Usage:
//   Raise start with req_func and req_value; the word is taken at the edge
//   where start is high and busy is low. busy is always low, so a word may
//   be offered in every cycle.
//   req_func 0 narrows a single to a half (truncating), 1 widens a half to a
//   single exactly.
//   The word is registered, converted by one level of combinational logic,
//   and registered again: rsp_valid pulses for one cycle with rsp_result
//   from the edge after the accepting edge, and the result is taken at the
//   edge that ends that pulse. Throughput is one word per cycle, set by the
//   single conversion stage between the two registers.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Reset clears both valid flags; words in flight are dropped.
module half_single_float_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_result
);

   hsfc_pkg::req_word_type req_ff;
   hsfc_pkg::req_word_type req_in;
   logic        req_valid_ff;
   logic        req_valid_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_result_ff;
   logic [31:0] rsp_result_in;

   assign busy = 1'b0;
   assign req_valid_in = start & ~busy;
   assign req_in = '{func: req_func, value: req_value};
   assign rsp_valid_in = req_valid_ff;

   hsfc_convert u_convert (
      .func   (req_ff.func),
      .value  (req_ff.value),
      .result (rsp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule
